@@ rtl/pnu_pkg.sv @@
// Package for the packed nibble unpacker.
// Holds the field widths, code constants and the result and push types.
// Used by pnu_unpack, pnu_result_fifo and packed_nibble_unpacker.
package pnu_pkg;

	localparam int unsigned DIGIT_W    = 10;
	localparam int unsigned MAX_DIGITS = 1023;
	localparam int unsigned CHAR_W     = 7;

	typedef enum logic [1:0] {
		FMT_BCD_RIGHT = 2'd0,
		FMT_BCD_LEFT  = 2'd1,
		FMT_HEX_RIGHT = 2'd2,
		FMT_HEX_ALT   = 2'd3
	} format_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_DIGIT = 2'd1,
		ST_BAD_PAD   = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]         packed_byte;
		logic [DIGIT_W-1:0] digit_count;
		logic [1:0]         format;
		logic               first_byte;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		status_t           status;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

@@ rtl/pnu_unpack.sv @@
// Per-byte unpack logic and field state for the packed nibble unpacker.
// Turns one registered byte into zero, one or two results combinationally.
// Depends on pnu_pkg.
module pnu_unpack #(
	parameter int unsigned MaxDigits = pnu_pkg::MAX_DIGITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sep_en,
	input  logic            item_valid,
	input  pnu_pkg::item_t  item,
	output pnu_pkg::push_t  push
);
	import pnu_pkg::*;

	localparam logic [DIGIT_W-1:0] DIGIT_CAP =
		(MaxDigits >= (2**DIGIT_W - 1)) ? {DIGIT_W{1'b1}} : DIGIT_W'(MaxDigits);
	localparam logic [3:0]        NIB_SEP   = 4'hD;
	localparam logic [3:0]        NIB_NINE  = 4'd9;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_HEXA = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_SEP  = 7'h5E;
	localparam logic [DIGIT_W-1:0] SEP_LOW  = DIGIT_W'(17);
	localparam logic [DIGIT_W-1:0] SEP_HIGH = DIGIT_W'(38);

	logic [DIGIT_W-1:0] byte_idx_q;
	logic               sep_seen_q;
	logic               failed_q;

	logic [DIGIT_W-1:0] idx, n, bytes, idx_nxt;
	logic [DIGIT_W:0]   n_plus;
	logic               seen, failed, past, odd, hex, left, is_last, sep_window;
	logic [3:0]         hi, lo;
	logic               pad_hi, pad_lo, hi_sep, lo_sep;
	logic               hi_emit, hi_fail, lo_emit, lo_fail;
	result_t            hi_res, lo_res;
	logic               seen_nxt, failed_nxt;

	function automatic logic [CHAR_W-1:0] nib_char(input logic [3:0] t, input logic is_hex,
		input logic is_sep);
		logic [CHAR_W-1:0] c;
		if (is_sep) begin
			c = CHAR_SEP;
		end else if (is_hex && t > NIB_NINE) begin
			c = CHAR_HEXA + {3'b000, t} - 7'd10;
		end else begin
			c = CHAR_ZERO + {3'b000, t};
		end
		return c;
	endfunction

	function automatic result_t make_res(input logic [CHAR_W-1:0] c, input status_t s,
		input logic l);
		result_t r;
		r.char_code = c;
		r.status    = s;
		r.last      = l;
		return r;
	endfunction

	always_comb begin
		idx    = item.first_byte ? '0 : byte_idx_q;
		seen   = item.first_byte ? 1'b0 : sep_seen_q;
		failed = item.first_byte ? 1'b0 : failed_q;

		n       = (item.digit_count > DIGIT_CAP) ? DIGIT_CAP : item.digit_count;
		n_plus  = {1'b0, n} + {{DIGIT_W{1'b0}}, 1'b1};
		bytes   = n_plus[DIGIT_W:1];
		past    = idx >= bytes;
		odd     = n[0];
		hex     = item.format[1];
		left    = format_t'(item.format) == FMT_BCD_LEFT;
		is_last = idx == (bytes - {{(DIGIT_W-1){1'b0}}, 1'b1});
		sep_window = sep_en && !hex && (n > SEP_LOW) && (n < SEP_HIGH);

		hi = item.packed_byte[7:4];
		lo = item.packed_byte[3:0];

		pad_hi  = !left && odd && (idx == '0);
		hi_sep  = !pad_hi && sep_window && !seen && (hi == NIB_SEP);
		hi_emit = 1'b0;
		hi_fail = 1'b0;
		hi_res  = make_res('0, ST_OK, 1'b0);
		if (pad_hi) begin
			if (hi != 4'd0) begin
				hi_fail = 1'b1;
				hi_res  = make_res('0, ST_BAD_PAD, 1'b1);
			end
		end else if (!hex && !hi_sep && hi > NIB_NINE) begin
			hi_fail = 1'b1;
			hi_res  = make_res('0, ST_NOT_DIGIT, 1'b1);
		end else begin
			hi_emit = 1'b1;
			hi_res  = make_res(nib_char(hi, hex, hi_sep), ST_OK, is_last && left && odd);
		end

		pad_lo  = left && odd && is_last;
		lo_sep  = !pad_lo && sep_window && !(seen || hi_sep) && (lo == NIB_SEP);
		lo_emit = 1'b0;
		lo_fail = 1'b0;
		lo_res  = make_res('0, ST_OK, 1'b0);
		if (pad_lo) begin
			if (lo != 4'd0) begin
				lo_fail = 1'b1;
				lo_emit = 1'b1;
				lo_res  = make_res('0, ST_BAD_PAD, 1'b1);
			end
		end else if (!hex && !lo_sep && lo > NIB_NINE) begin
			lo_fail = 1'b1;
			lo_emit = 1'b1;
			lo_res  = make_res('0, ST_NOT_DIGIT, 1'b1);
		end else begin
			lo_emit = 1'b1;
			lo_res  = make_res(nib_char(lo, hex, lo_sep), ST_OK, is_last);
		end

		push       = '0;
		idx_nxt    = idx;
		seen_nxt   = seen;
		failed_nxt = failed;
		if (item_valid && !failed && !past) begin
			if (hi_fail) begin
				push.cnt   = 2'd1;
				push.r0    = hi_res;
				failed_nxt = 1'b1;
			end else begin
				push.cnt   = {1'b0, hi_emit} + {1'b0, lo_emit};
				push.r0    = hi_emit ? hi_res : lo_res;
				push.r1    = lo_res;
				seen_nxt   = seen || hi_sep || lo_sep;
				failed_nxt = lo_fail;
				if (!lo_fail) begin
					idx_nxt = idx + {{(DIGIT_W-1){1'b0}}, 1'b1};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			sep_seen_q <= 1'b0;
			failed_q   <= 1'b0;
		end else if (item_valid) begin
			byte_idx_q <= idx_nxt;
			sep_seen_q <= seen_nxt;
			failed_q   <= failed_nxt;
		end
	end

endmodule

@@ rtl/pnu_result_fifo.sv @@
// Four-entry result queue for the packed nibble unpacker.
// Takes up to two results per cycle and hands out one per transaction.
// Depends on pnu_pkg.
module pnu_result_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  pnu_pkg::push_t   push,
	input  logic             pop,
	output logic             has_room,
	output logic             not_empty,
	output pnu_pkg::result_t head
);
	import pnu_pkg::*;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic [PTR_W-1:0]   wr_ptr_p1;
	logic               do_pop;

	assign wr_ptr_p1 = wr_ptr_q + {{(PTR_W-1){1'b0}}, 1'b1};
	assign not_empty = count_q != '0;
	assign has_room  = count_q <= (PTR_W+1)'(DEPTH - 2);
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + {{(PTR_W-1){1'b0}}, 1'b1};
			end
			count_q <= count_q + (PTR_W+1)'(push.cnt) - {{PTR_W{1'b0}}, do_pop};
		end
	end

endmodule

@@ rtl/packed_nibble_unpacker.sv @@
// Packed nibble unpacker: one packed byte in, up to two ASCII results out.
// An input byte is registered in the input stage, unpacked into the result queue and shown from its head.
// The sustained byte rate is limited by the single-result output port.
// A byte is taken in any cycle while the input stage is empty or the result queue has room for two entries.
// Reset clears the field state and the queue and sets separator_enable to one.
module packed_nibble_unpacker #(
	parameter int unsigned MaxDigits = pnu_pkg::MAX_DIGITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   packed_byte,
	input  logic [pnu_pkg::DIGIT_W-1:0]  digit_count,
	input  logic [1:0]                   format,
	input  logic                         first_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pnu_pkg::CHAR_W-1:0]   char_code,
	output logic [1:0]                   status,
	output logic                         last
);
	import pnu_pkg::*;

	logic    sep_en_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    has_room;
	logic    advance;
	push_t   push;
	result_t head;

	assign advance  = valid_s1 && has_room;
	assign in_stall = valid_s1 && !has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_en_q <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sep_en_q <= cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.packed_byte <= packed_byte;
			item_s1.digit_count <= digit_count;
			item_s1.format      <= format;
			item_s1.first_byte  <= first_byte;
		end
	end

	pnu_unpack #(
		.MaxDigits(MaxDigits)
	) u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.sep_en    (sep_en_q),
		.item_valid(advance),
		.item      (item_s1),
		.push      (push)
	);

	pnu_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (!out_stall),
		.has_room (has_room),
		.not_empty(out_valid),
		.head     (head)
	);

	assign char_code = head.char_code;
	assign status    = head.status;
	assign last      = head.last;

endmodule

@@ tb/pnu_result_check.sv @@
// Result checker for the packed nibble unpacker testbench.
// Watches both channels and the register port, predicts the characters of each byte
// and compares them in order. Depends on pnu_pkg for the field widths and codes.
module pnu_result_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [7:0]                  packed_byte,
	input  logic [pnu_pkg::DIGIT_W-1:0] digit_count,
	input  logic [1:0]                  format,
	input  logic                        first_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [pnu_pkg::CHAR_W-1:0]  char_code,
	input  logic [1:0]                  status,
	input  logic                        last,
	output int unsigned                 fail_count,
	output int unsigned                 pending,
	output int unsigned                 chars_checked,
	output int unsigned                 live_bytes
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [6:0] CH_ZERO = 7'h30;
	localparam logic [6:0] CH_A = 7'h41;
	localparam logic [6:0] CH_SEP = 7'h5E;
	localparam int unsigned SEP_MIN_DIGITS = 18;
	localparam int unsigned SEP_MAX_DIGITS = 37;

	pnu_pkg::result_t expected_chars[$];
	int unsigned      byte_idx = 0;
	bit               sep_seen = 1'b0;
	bit               field_failed = 1'b0;
	bit               sep_en = 1'b1;
	int unsigned      errors = 0;
	int unsigned      checked = 0;
	int unsigned      productive = 0;

	task automatic expect_char(input logic [6:0] ch, input pnu_pkg::status_t st,
			input logic lst);
		pnu_pkg::result_t r;
		r.char_code = ch;
		r.status = st;
		r.last = lst;
		expected_chars.push_back(r);
	endtask

	task automatic decode_nibble(input logic [3:0] nib, input bit hex, input logic [9:0] n,
			output logic [6:0] ch, output pnu_pkg::status_t st);
		st = pnu_pkg::ST_OK;
		ch = '0;
		if (hex) begin
			ch = (nib > 4'd9) ? CH_A + nib - 7'd10 : CH_ZERO + nib;
		end else if (sep_en && n >= SEP_MIN_DIGITS && n <= SEP_MAX_DIGITS && !sep_seen
				&& nib == 4'hD) begin
			sep_seen = 1'b1;
			ch = CH_SEP;
		end else if (nib > 4'd9) begin
			st = pnu_pkg::ST_NOT_DIGIT;
		end else begin
			ch = CH_ZERO + nib;
		end
	endtask

	task automatic unpack_byte(input logic [7:0] b, input logic [9:0] n, input logic [1:0] fmt,
			input logic first);
		int unsigned nbytes;
		int unsigned before_cnt;
		bit odd, hex, left, fin, skip, err;
		logic [6:0] ch;
		pnu_pkg::status_t st;
		if (first) begin
			byte_idx = 0;
			sep_seen = 1'b0;
			field_failed = 1'b0;
		end
		before_cnt = expected_chars.size();
		nbytes = (n + 1) / 2;
		skip = field_failed || byte_idx >= nbytes;
		err = 1'b0;
		odd = n[0];
		hex = (fmt == pnu_pkg::FMT_HEX_RIGHT) || (fmt == pnu_pkg::FMT_HEX_ALT);
		left = (fmt == pnu_pkg::FMT_BCD_LEFT);
		fin = !skip && (byte_idx == nbytes - 1);
		if (!skip) begin
			if (!left && odd && byte_idx == 0) begin
				if (b[7:4] != 4'h0) begin
					expect_char('0, pnu_pkg::ST_BAD_PAD, 1'b1);
					err = 1'b1;
				end
			end else begin
				decode_nibble(b[7:4], hex, n, ch, st);
				if (st != pnu_pkg::ST_OK) begin
					expect_char('0, st, 1'b1);
					err = 1'b1;
				end else begin
					expect_char(ch, pnu_pkg::ST_OK, fin && left && odd);
				end
			end
		end
		if (!skip && !err) begin
			if (left && odd && fin) begin
				if (b[3:0] != 4'h0) begin
					expect_char('0, pnu_pkg::ST_BAD_PAD, 1'b1);
					err = 1'b1;
				end
			end else begin
				decode_nibble(b[3:0], hex, n, ch, st);
				if (st != pnu_pkg::ST_OK) begin
					expect_char('0, st, 1'b1);
					err = 1'b1;
				end else begin
					expect_char(ch, pnu_pkg::ST_OK, fin);
				end
			end
		end
		if (err)
			field_failed = 1'b1;
		else if (!skip)
			byte_idx++;
		if (expected_chars.size() != before_cnt)
			productive++;
	endtask

	task automatic check_char();
		pnu_pkg::result_t want;
		if (expected_chars.size() == 0) begin
			errors++;
			$error("unexpected result: char_code %0h status %0d last %0b",
				char_code, status, last);
		end else begin
			want = expected_chars.pop_front();
			checked++;
			if (char_code !== want.char_code) begin
				errors++;
				$error("char_code mismatch: expected %0h, actual %0h", want.char_code, char_code);
			end
			if (status !== want.status) begin
				errors++;
				$error("status mismatch: expected %0d, actual %0d", want.status, status);
			end
			if (last !== want.last) begin
				errors++;
				$error("last mismatch: expected %0b, actual %0b", want.last, last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx = 0;
			sep_seen = 1'b0;
			field_failed = 1'b0;
			sep_en = 1'b1;
			expected_chars.delete();
			fail_count <= errors;
			pending <= 0;
			chars_checked <= checked;
			live_bytes <= productive;
		end else begin
			if (cfg_wr_en)
				sep_en = cfg_wr_data;
			if (out_valid && !out_stall)
				check_char();
			if (in_valid && !in_stall)
				unpack_byte(packed_byte, digit_count, format, first_byte);
			fail_count <= errors;
			pending <= expected_chars.size();
			chars_checked <= checked;
			live_bytes <= productive;
		end
	end

endmodule

@@ tb/packed_nibble_unpacker_tb.sv @@
// Top of the packed nibble unpacker testbench: clock, reset, stimulus and verdict.
// Drives directed and random packed fields with random gaps and stalls on both sides.
// Depends on pnu_pkg, the packed_nibble_unpacker block and pnu_result_check.
module packed_nibble_unpacker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_PAUSE = 8;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PHASE_BYTES = 250;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic                        cfg_wr_data;
	logic                        in_valid;
	logic                        in_stall;
	logic [7:0]                  packed_byte;
	logic [pnu_pkg::DIGIT_W-1:0] digit_count;
	logic [1:0]                  format;
	logic                        first_byte;
	logic                        out_valid;
	logic                        out_stall;
	logic [pnu_pkg::CHAR_W-1:0]  char_code;
	logic [1:0]                  status;
	logic                        last;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned chars_checked;
	int unsigned live_bytes;

	int unsigned send_idle_pct = 40;
	int unsigned recv_idle_pct = 40;
	bit          hold_req = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned fields_sent = 0;
	int unsigned cfg_writes = 0;
	int unsigned idle_cycles = 0;

	packed_nibble_unpacker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.packed_byte(packed_byte),
		.digit_count(digit_count),
		.format     (format),
		.first_byte (first_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_code  (char_code),
		.status     (status),
		.last       (last)
	);

	pnu_result_check result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.packed_byte  (packed_byte),
		.digit_count  (digit_count),
		.format       (format),
		.first_byte   (first_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.char_code    (char_code),
		.status       (status),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending),
		.chars_checked(chars_checked),
		.live_bytes   (live_bytes)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
						idle_cycles, pending);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	function automatic int unsigned gap_len();
		return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 4) : $urandom_range(15, 60);
	endfunction

	initial begin
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 99) < recv_idle_pct) begin
				out_stall <= 1'b1;
				repeat (gap_len()) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic sender_gap();
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic [9:0] n, input logic [1:0] fmt,
			input logic first);
		in_valid <= 1'b1;
		packed_byte <= b;
		digit_count <= n;
		format <= fmt;
		first_byte <= first;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		sender_gap();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic set_separator(input bit enable);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= enable;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_writes++;
	endtask

	function automatic logic [3:0] rand_nibble(input bit hex);
		if (hex)
			return 4'($urandom_range(0, 15));
		if ($urandom_range(0, 59) == 0)
			return 4'($urandom_range(10, 15));
		return 4'($urandom_range(0, 9));
	endfunction

	function automatic logic [3:0] pad_nibble();
		return ($urandom_range(0, 39) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
	endfunction

	task automatic send_field(input int unsigned n, input logic [1:0] fmt, input bit noisy);
		int unsigned nb, count, i, sep_pos, kind;
		bit left, odd, hex, sep_try, first;
		logic [3:0] hi, lo;
		kind = noisy ? $urandom_range(0, 3) : 4;
		if (kind == 0 && $urandom_range(0, 1) == 1)
			n = $urandom_range(0, 1023);
		nb = (n + 1) / 2;
		left = (fmt == pnu_pkg::FMT_BCD_LEFT);
		hex = (fmt == pnu_pkg::FMT_HEX_RIGHT) || (fmt == pnu_pkg::FMT_HEX_ALT);
		odd = (n % 2) == 1;
		count = nb;
		if (kind == 0)
			count = $urandom_range(1, (nb > 6) ? 6 : ((nb > 0) ? nb : 1));
		if (kind == 1)
			count = nb + $urandom_range(1, 3);
		if (count == 0)
			count = 1;
		sep_try = !hex && n >= 18 && n <= 37 && $urandom_range(0, 2) == 0;
		sep_pos = sep_try ? $urandom_range(0, 2 * nb - 1) : 0;
		fields_sent++;
		for (i = 0; i < count; i++) begin
			hi = rand_nibble(hex);
			lo = rand_nibble(hex);
			if (kind == 3) begin
				{hi, lo} = 8'($urandom_range(0, 255));
			end else begin
				if (!left && odd && i == 0)
					hi = pad_nibble();
				if (left && odd && i == nb - 1)
					lo = pad_nibble();
				if (sep_try && sep_pos == 2 * i)
					hi = 4'hD;
				if (sep_try && sep_pos == 2 * i + 1)
					lo = 4'hD;
			end
			first = (i == 0) && (kind != 2);
			send_byte({hi, lo}, 10'(n), fmt, first);
		end
	endtask

	initial begin
		int unsigned p, start, n, r;
		logic [1:0] fmt;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		packed_byte = '0;
		digit_count = '0;
		format = pnu_pkg::FMT_BCD_RIGHT;
		first_byte = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h12, 4, pnu_pkg::FMT_BCD_RIGHT, 1'b0);
		send_byte(8'h34, 4, pnu_pkg::FMT_BCD_RIGHT, 1'b0);
		send_byte(8'h01, 3, pnu_pkg::FMT_BCD_RIGHT, 1'b1);
		send_byte(8'h23, 3, pnu_pkg::FMT_BCD_RIGHT, 1'b0);
		send_byte(8'h51, 3, pnu_pkg::FMT_BCD_RIGHT, 1'b1);
		send_byte(8'h23, 3, pnu_pkg::FMT_BCD_RIGHT, 1'b0);
		send_byte(8'h12, 3, pnu_pkg::FMT_BCD_LEFT, 1'b1);
		send_byte(8'h30, 3, pnu_pkg::FMT_BCD_LEFT, 1'b0);
		send_byte(8'h12, 3, pnu_pkg::FMT_BCD_LEFT, 1'b1);
		send_byte(8'h34, 3, pnu_pkg::FMT_BCD_LEFT, 1'b0);
		send_byte(8'hAF, 2, pnu_pkg::FMT_HEX_RIGHT, 1'b1);
		send_byte(8'hB9, 2, pnu_pkg::FMT_HEX_ALT, 1'b1);
		send_byte(8'hFF, 2, pnu_pkg::FMT_HEX_RIGHT, 1'b1);
		send_byte(8'h1A, 2, pnu_pkg::FMT_BCD_RIGHT, 1'b1);
		send_byte(8'hC1, 2, pnu_pkg::FMT_BCD_RIGHT, 1'b1);
		send_byte(8'hD1, 18, pnu_pkg::FMT_BCD_RIGHT, 1'b1);
		send_byte(8'hD2, 18, pnu_pkg::FMT_BCD_RIGHT, 1'b0);
		send_byte(8'h3D, 37, pnu_pkg::FMT_BCD_LEFT, 1'b1);
		send_byte(8'h1D, 38, pnu_pkg::FMT_BCD_RIGHT, 1'b1);
		send_byte(8'hD0, 17, pnu_pkg::FMT_BCD_LEFT, 1'b1);
		send_byte(8'h05, 1, pnu_pkg::FMT_BCD_RIGHT, 1'b1);
		send_byte(8'h77, 1, pnu_pkg::FMT_BCD_RIGHT, 1'b0);
		send_byte(8'h11, 0, pnu_pkg::FMT_BCD_RIGHT, 1'b1);
		send_byte(8'h09, 1023, pnu_pkg::FMT_BCD_RIGHT, 1'b1);
		set_separator(1'b0);
		send_byte(8'hD1, 20, pnu_pkg::FMT_BCD_RIGHT, 1'b1);

		for (p = 0; p < PHASES; p++) begin
			if (p == 0)
				set_separator(1'b0);
			else if (p == 1)
				set_separator(1'b1);
			else
				set_separator(1'($urandom_range(0, 1)));
			send_idle_pct = (p == 1 || p == 3) ? 0 : 40;
			recv_idle_pct = (p == 3) ? 0 : 40;
			if (p == 1)
				hold_req = 1'b1;
			start = bytes_sent;
			if (p == 2)
				send_field(1023, pnu_pkg::FMT_BCD_RIGHT, 1'b0);
			while (bytes_sent - start < PHASE_BYTES) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					n = $urandom_range(1, 17);
				else if (r < 85)
					n = $urandom_range(18, 37);
				else if (r < 99)
					n = $urandom_range(38, 80);
				else
					n = $urandom_range(0, 1023);
				fmt = 2'($urandom_range(0, 3));
				send_field(n, fmt, $urandom_range(0, 9) == 0);
			end
		end

		wait_idle();
		$display("Sent %0d bytes in %0d fields; %0d bytes produced characters, %0d results checked.",
			bytes_sent, fields_sent, live_bytes, chars_checked);
		$display("Separator enable written %0d times, with gaps and stalls on both channels.",
			cfg_writes);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
